// ===== rtl/mur64_pkg.sv =====
package mur64_pkg;

  localparam logic [63:0] MUL_M      = 64'hc6a4_a793_5bd1_e995;
  localparam int          SHIFT_R    = 47;
  localparam logic [63:0] SEED_RESET = 64'd97;

  localparam int DATA_W  = 64;
  localparam int COUNT_W = 4;
  localparam int LEN_W   = 16;

  // multiplier operand source
  localparam logic [1:0] SRC_WORD = 2'd0;
  localparam logic [1:0] SRC_LEN  = 2'd1;
  localparam logic [1:0] SRC_K    = 2'd2;
  localparam logic [1:0] SRC_ACC  = 2'd3;

  // register writeback operations
  localparam logic [2:0] WB_NONE    = 3'd0;
  localparam logic [2:0] WB_INIT    = 3'd1;
  localparam logic [2:0] WB_K_SHX   = 3'd2;
  localparam logic [2:0] WB_ACC_XOR = 3'd3;
  localparam logic [2:0] WB_ACC     = 3'd4;
  localparam logic [2:0] WB_TAIL    = 3'd5;
  localparam logic [2:0] WB_FIN_SHX = 3'd6;
  localparam logic [2:0] WB_HASH    = 3'd7;

  typedef struct packed {
    logic       capture;
    logic       mul_en;
    logic [1:0] mul_step;
    logic [1:0] mul_src;
    logic [2:0] wb;
  } cmd_t;

  typedef struct packed {
    logic first;
    logic last;
    logic full;
    logic partial;
  } stat_t;

endpackage

// ===== rtl/mur64_if.sv =====
interface mur64_in_if;
  logic                             valid;
  logic                             ready;
  logic [mur64_pkg::DATA_W-1:0]     data_word;
  logic [mur64_pkg::COUNT_W-1:0]    byte_count;
  logic                             msg_start;
  logic                             is_last;
  logic [mur64_pkg::LEN_W-1:0]      message_length;

  modport source (
    output valid, data_word, byte_count, msg_start, is_last, message_length,
    input  ready
  );
  modport sink (
    input  valid, data_word, byte_count, msg_start, is_last, message_length,
    output ready
  );
endinterface

interface mur64_out_if;
  logic                         valid;
  logic                         ready;
  logic [mur64_pkg::DATA_W-1:0] hash_value;

  modport source (output valid, hash_value, input ready);
  modport sink (input valid, hash_value, output ready);
endinterface

// ===== rtl/mur64_datapath.sv =====
module mur64_datapath (
  input  logic                          clk,
  input  mur64_pkg::cmd_t               cmd,
  output mur64_pkg::stat_t              stat,
  input  logic [mur64_pkg::DATA_W-1:0]  seed,
  input  logic [mur64_pkg::DATA_W-1:0]  data_word,
  input  logic [mur64_pkg::COUNT_W-1:0] byte_count,
  input  logic                          msg_start,
  input  logic                          is_last,
  input  logic [mur64_pkg::LEN_W-1:0]   message_length,
  output logic [mur64_pkg::DATA_W-1:0]  hash
);

  logic [63:0] word_q;
  logic [2:0]  cnt_q;
  logic        first_q;
  logic        last_q;
  logic        full_q;
  logic        partial_q;
  logic [15:0] len_q;
  logic [63:0] k;
  logic [63:0] acc;
  logic [63:0] prod;

  logic [63:0] opnd;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] pp;
  logic [63:0] tail_mask;

  assign stat = '{first: first_q, last: last_q, full: full_q, partial: partial_q};

  // capture the accepted item
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      word_q    <= data_word;
      cnt_q     <= byte_count[2:0];
      first_q   <= msg_start;
      last_q    <= is_last;
      full_q    <= byte_count[3];
      partial_q <= !byte_count[3] && (byte_count[2:0] != 3'd0);
      len_q     <= message_length;
    end
  end

  always_comb begin
    case (cmd.mul_src)
      mur64_pkg::SRC_WORD: opnd = word_q;
      mur64_pkg::SRC_LEN:  opnd = {48'd0, len_q};
      mur64_pkg::SRC_K:    opnd = k;
      mur64_pkg::SRC_ACC:  opnd = acc;
      default:             opnd = '0;
    endcase
  end

  // shared 32x32 multiplier: lo*lo, then the two cross terms into the top half
  assign mul_a = (cmd.mul_step == 2'd2) ? opnd[63:32] : opnd[31:0];
  assign mul_b = (cmd.mul_step == 2'd1) ? mur64_pkg::MUL_M[63:32] : mur64_pkg::MUL_M[31:0];
  assign pp    = 64'(mul_a) * 64'(mul_b);

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      if (cmd.mul_step == 2'd0) begin
        prod <= pp;
      end else begin
        prod[63:32] <= prod[63:32] + pp[31:0];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      tail_mask[8*i +: 8] = (3'(i) < cnt_q) ? 8'hff : 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.wb)
      mur64_pkg::WB_INIT:    acc  <= seed ^ prod;
      mur64_pkg::WB_K_SHX:   k    <= prod ^ (prod >> mur64_pkg::SHIFT_R);
      mur64_pkg::WB_ACC_XOR: acc  <= acc ^ prod;
      mur64_pkg::WB_ACC:     acc  <= prod;
      mur64_pkg::WB_TAIL:    acc  <= acc ^ (word_q & tail_mask);
      mur64_pkg::WB_FIN_SHX: acc  <= acc ^ (acc >> mur64_pkg::SHIFT_R);
      mur64_pkg::WB_HASH:    hash <= prod ^ (prod >> mur64_pkg::SHIFT_R);
      default: ;
    endcase
  end

endmodule

// ===== rtl/mur64_ctrl.sv =====
module mur64_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             words_valid,
  output logic             words_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  mur64_pkg::stat_t stat,
  output mur64_pkg::cmd_t  cmd
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DISPATCH = 4'd1;
  localparam logic [3:0] S_INIT_M   = 4'd2;
  localparam logic [3:0] S_INIT_WB  = 4'd3;
  localparam logic [3:0] S_BODY     = 4'd4;
  localparam logic [3:0] S_K1_M     = 4'd5;
  localparam logic [3:0] S_K1_WB    = 4'd6;
  localparam logic [3:0] S_K2_M     = 4'd7;
  localparam logic [3:0] S_K2_WB    = 4'd8;
  localparam logic [3:0] S_TAIL     = 4'd9;
  localparam logic [3:0] S_A_M      = 4'd10;
  localparam logic [3:0] S_A_WB     = 4'd11;
  localparam logic [3:0] S_END      = 4'd12;
  localparam logic [3:0] S_FIN_SHX  = 4'd13;
  localparam logic [3:0] S_F_M      = 4'd14;
  localparam logic [3:0] S_F_WB     = 4'd15;

  logic [3:0] state;
  logic [3:0] state_next;
  logic [1:0] step;
  logic [1:0] step_next;
  logic       in_message;
  logic       in_message_next;
  logic       out_valid_next;
  logic       load_hash;
  logic       step_done;

  assign step_done   = (step == 2'd2);
  assign words_ready = (state == S_IDLE);

  always_comb begin
    state_next      = state;
    in_message_next = in_message;
    load_hash       = 1'b0;
    cmd             = '{capture: 1'b0, mul_en: 1'b0, mul_step: step,
                        mul_src: mur64_pkg::SRC_WORD, wb: mur64_pkg::WB_NONE};
    case (state)
      S_IDLE: begin
        if (words_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (stat.first) begin
          in_message_next = 1'b1;
          state_next      = S_INIT_M;
        end else if (!in_message) begin
          state_next = S_IDLE;
        end else begin
          state_next = S_BODY;
        end
      end
      S_INIT_M: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_src = mur64_pkg::SRC_LEN;
        if (step_done) state_next = S_INIT_WB;
      end
      S_INIT_WB: begin
        cmd.wb     = mur64_pkg::WB_INIT;
        state_next = S_BODY;
      end
      S_BODY: begin
        if (stat.full) begin
          state_next = S_K1_M;
        end else if (stat.partial) begin
          state_next = S_TAIL;
        end else begin
          state_next = S_END;
        end
      end
      S_K1_M: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_src = mur64_pkg::SRC_WORD;
        if (step_done) state_next = S_K1_WB;
      end
      S_K1_WB: begin
        cmd.wb     = mur64_pkg::WB_K_SHX;
        state_next = S_K2_M;
      end
      S_K2_M: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_src = mur64_pkg::SRC_K;
        if (step_done) state_next = S_K2_WB;
      end
      S_K2_WB: begin
        cmd.wb     = mur64_pkg::WB_ACC_XOR;
        state_next = S_A_M;
      end
      S_TAIL: begin
        cmd.wb     = mur64_pkg::WB_TAIL;
        state_next = S_A_M;
      end
      S_A_M: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_src = mur64_pkg::SRC_ACC;
        if (step_done) state_next = S_A_WB;
      end
      S_A_WB: begin
        cmd.wb     = mur64_pkg::WB_ACC;
        state_next = S_END;
      end
      S_END: begin
        state_next = stat.last ? S_FIN_SHX : S_IDLE;
      end
      S_FIN_SHX: begin
        cmd.wb     = mur64_pkg::WB_FIN_SHX;
        state_next = S_F_M;
      end
      S_F_M: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_src = mur64_pkg::SRC_ACC;
        if (step_done) state_next = S_F_WB;
      end
      S_F_WB: begin
        // hold the product until the output register is free
        if (!out_valid || out_ready) begin
          cmd.wb          = mur64_pkg::WB_HASH;
          load_hash       = 1'b1;
          in_message_next = 1'b0;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign step_next      = (cmd.mul_en && !step_done) ? step + 2'd1 : 2'd0;
  assign out_valid_next = load_hash || (out_valid && !out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      step       <= 2'd0;
      in_message <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      step       <= step_next;
      in_message <= in_message_next;
      out_valid  <= out_valid_next;
    end
  end

  a_accept_dispatch: assert property (@(posedge clk) disable iff (rst)
    (words_valid && words_ready) |=> (state == S_DISPATCH))
    else $error("accepted item did not reach dispatch");

  a_step_advance: assert property (@(posedge clk) disable iff (rst)
    (cmd.mul_en && !step_done) |=> (step == $past(step) + 2'd1))
    else $error("multiplier step did not advance");

  a_result_after_last: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_F_WB && stat.last))
    else $error("result raised without a final word");

  a_message_closed: assert property (@(posedge clk) disable iff (rst)
    load_hash |=> (!in_message && state == S_IDLE))
    else $error("message still open after its result");

endmodule

// ===== rtl/murmur64a_hash.sv =====
// MurmurHash64A engine. Feed a message as little-endian 64-bit items on the
// words channel: the first item sets msg_start and carries message_length,
// full items have byte_count 8 (9 to 15 also count as full), a final item
// with 1 to 7 bytes holds the tail, and the item with is_last closes the
// message (an empty message is one item with msg_start, is_last and
// byte_count 0). One 64-bit hash leaves on the hashes channel per message.
// Items are taken one at a time; all 64-bit multiplies by the constant run
// through a single shared 32x32 multiplier, partial product by partial
// product, each followed by a writeback. A first word adds the length
// multiply, and a last word adds the final avalanche, which waits while the
// previous hash is still not taken. An item without msg_start outside a
// message is dropped. A new msg_start abandons any running message. The
// seed register (APB, byte address 0, reset 97) may be written only while
// the engine is idle.
module murmur64a_hash (
  input  logic                clk,
  input  logic                rst,
  mur64_in_if.sink            words,
  mur64_out_if.source         hashes,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [63:0]         pwdata,
  output logic [63:0]         prdata,
  output logic                pready
);

  logic             [63:0] seed;
  mur64_pkg::cmd_t         cmd;
  mur64_pkg::stat_t        stat;

  // Configuration: single 64-bit seed register at byte address 0.
  assign pready = 1'b1;
  assign prdata = (paddr == 4'd0) ? seed : 64'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= mur64_pkg::SEED_RESET;
    end else if (psel && penable && pwrite && pready && (paddr == 4'd0)) begin
      seed <= pwdata;
    end
  end

  // Sequencer: walks each item through init, mix, tail and avalanche steps.
  mur64_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .words_valid (words.valid),
    .words_ready (words.ready),
    .out_valid   (hashes.valid),
    .out_ready   (hashes.ready),
    .stat        (stat),
    .cmd         (cmd)
  );

  // Datapath: item capture, shared multiplier, accumulator and hash register.
  mur64_datapath u_datapath (
    .clk            (clk),
    .cmd            (cmd),
    .stat           (stat),
    .seed           (seed),
    .data_word      (words.data_word),
    .byte_count     (words.byte_count),
    .msg_start      (words.msg_start),
    .is_last        (words.is_last),
    .message_length (words.message_length),
    .hash           (hashes.hash_value)
  );

endmodule

// ===== tb/sv/murmur64a_hash_tb.sv =====
`timescale 1ns / 1ps

module murmur64a_hash_tb;

  // Seed register sits at byte address 0 (64-bit register).
  localparam logic [3:0] SEED_ADDR = 4'd0;

  // Cycles to let pass after the last hash before touching the seed or ending.
  localparam int SETTLE_CYCLES = 40;
  localparam int DRAIN_GUARD   = 20000;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASE_WORDS   = 140;

  typedef struct {
    logic [63:0] data;
    logic [3:0]  count;
    logic        first;
    logic        last;
    logic [15:0] len;
  } word_item_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;
  logic        long_hold;

  mur64_in_if  words_if ();
  mur64_out_if hash_if ();

  murmur64a_hash DUT (
    .clk     (clk),
    .rst     (rst),
    .words   (words_if.sink),
    .hashes  (hash_if.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Words waiting to be offered, and hashes the engine still owes us.
  word_item_t  pending_words[$];
  logic [63:0] expected_hashes[$];

  // Local copy of the engine state, advanced on every accepted item.
  logic [63:0] seed_copy;
  logic [63:0] acc_state;
  logic        msg_open;

  word_item_t cur_word;
  logic       offering;
  int         burst_left;
  int         gap_left;

  logic [11:0] stall_pat;
  int          pat_age;

  int err_count;
  int items_taken;
  int hashes_checked;
  int strays_dropped;
  int seeds_used;

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------
  // Hash arithmetic, all modulo 2^64
  // ---------------------------------------------------------------------

  // Full 8-byte block scramble: multiply, fold the high bits down, multiply.
  function automatic logic [63:0] scramble_block(logic [63:0] k);
    logic [63:0] t;
    t = k * mur64_pkg::MUL_M;
    t = t ^ (t >> mur64_pkg::SHIFT_R);
    t = t * mur64_pkg::MUL_M;
    return t;
  endfunction

  // Final avalanche: fold, multiply, fold.
  function automatic logic [63:0] avalanche(logic [63:0] h);
    logic [63:0] t;
    t = h ^ (h >> mur64_pkg::SHIFT_R);
    t = t * mur64_pkg::MUL_M;
    t = t ^ (t >> mur64_pkg::SHIFT_R);
    return t;
  endfunction

  // Advance the local engine state by one accepted item and queue the hash
  // it closes, if any.
  task automatic absorb_word(input word_item_t it);
    int unsigned nbytes;
    logic [63:0] mask;
    // Byte counts above 8 behave as a full word.
    nbytes = (it.count > 4'd8) ? 8 : int'(it.count);
    if (it.first) begin
      // A first word always restarts, abandoning any open message.
      acc_state = seed_copy ^ ({48'd0, it.len} * mur64_pkg::MUL_M);
      msg_open  = 1'b1;
    end
    if (!msg_open) begin
      // Stray word outside a message: dropped without a trace.
      strays_dropped++;
    end else begin
      if (nbytes == 8) begin
        acc_state = (acc_state ^ scramble_block(it.data)) * mur64_pkg::MUL_M;
      end else if (nbytes != 0) begin
        // Tail bytes: keep only the valid low bytes, no block scramble.
        mask      = (64'd1 << (8 * nbytes)) - 64'd1;
        acc_state = (acc_state ^ (it.data & mask)) * mur64_pkg::MUL_M;
      end
      if (it.last) begin
        expected_hashes.push_back(avalanche(acc_state));
        acc_state = '0;
        msg_open  = 1'b0;
      end
    end
  endtask

  task automatic note_mismatch(input string what, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
    err_count++;
    if (err_count <= 10)
      $display("MISMATCH %s: expected %016h, got %016h at %0t", what, exp_v, act_v, $realtime);
  endtask

  // ---------------------------------------------------------------------
  // Item driver: bursts of random length separated by random gaps
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : drv
    logic offer;
    if (rst) begin
      words_if.valid <= 1'b0;
      offering   = 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      offer = words_if.valid;
      // Retire the offered item when the engine takes it.
      if (words_if.valid && words_if.ready) begin
        absorb_word(cur_word);
        items_taken++;
        offer = 1'b0;
      end
      if (!offer) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (pending_words.size() != 0) begin
          cur_word = pending_words.pop_front();
          words_if.data_word      <= cur_word.data;
          words_if.byte_count     <= cur_word.count;
          words_if.msg_start      <= cur_word.first;
          words_if.is_last        <= cur_word.last;
          words_if.message_length <= cur_word.len;
          offer = 1'b1;
          if (burst_left > 0)
            burst_left--;
          // End of a burst: pick the next burst and the pause before it.
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
          end
        end
      end
      // Keep valid high across back-to-back items: one assignment per edge.
      offering = offer;
      words_if.valid <= offer;
    end
  end

  // ---------------------------------------------------------------------
  // Hash receiver: stalls on a rotating pattern, reloaded now and then
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : rcv
    if (rst) begin
      hash_if.ready <= 1'b0;
      stall_pat = '1;
      pat_age   = 0;
    end else begin
      if (pat_age == 0) begin
        pat_age = $urandom_range(20, 120);
        // A quarter of the windows take every hash without stalling.
        if ($urandom_range(0, 3) == 0)
          stall_pat = '1;
        else
          stall_pat = 12'($urandom_range(0, 4095));
      end else begin
        pat_age--;
      end
      hash_if.ready <= stall_pat[0] && !long_hold;
      stall_pat = {stall_pat[0], stall_pat[11:1]};
    end
  end

  // ---------------------------------------------------------------------
  // Hash checker: compare each taken hash with the oldest one owed
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : chk
    logic [63:0] want;
    if (!rst && hash_if.valid && hash_if.ready) begin
      if (expected_hashes.size() == 0) begin
        note_mismatch("hash with no message closed", '0, hash_if.hash_value);
      end else begin
        want = expected_hashes.pop_front();
        hashes_checked++;
        if (hash_if.hash_value !== want)
          note_mismatch("hash_value", want, hash_if.hash_value);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  // Mostly random, with the occasional all-zero or all-one word.
  function automatic logic [63:0] rand64();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic queue_word(input logic [63:0] d, input logic [3:0] c, input logic f,
                            input logic l, input logic [15:0] n);
    word_item_t it;
    it.data  = d;
    it.count = c;
    it.first = f;
    it.last  = l;
    it.len   = n;
    pending_words.push_back(it);
  endtask

  // Queue one message of nbytes bytes with len in the length field. Full
  // words sometimes carry an oversized count; later words carry a junk
  // length, which the engine must ignore.
  task automatic queue_message(input logic [15:0] len, input int unsigned nbytes,
                               output int unsigned words);
    int unsigned full_words;
    int unsigned tail;
    logic [3:0]  c;
    full_words = nbytes / 8;
    tail       = nbytes % 8;
    words      = full_words + ((tail != 0) ? 1 : 0);
    if (words == 0)
      words = 1;
    for (int unsigned i = 0; i < words; i++) begin
      if (i < full_words)
        c = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(9, 15)) : 4'd8;
      else
        c = 4'(tail);
      queue_word(rand64(), c, i == 0, i == words - 1,
                 (i == 0) ? len : 16'($urandom_range(0, 65535)));
    end
  endtask

  // Hold until every queued item is taken and every owed hash has arrived,
  // then let the engine finish whatever it may still be chewing on.
  task automatic settle();
    int guard;
    guard = 0;
    while ((pending_words.size() != 0 || offering || expected_hashes.size() != 0) &&
           guard < DRAIN_GUARD) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One APB transfer: setup, access, then hold until pready.
  task automatic apb_xfer(input logic wr, input logic [63:0] wdata,
                          output logic [63:0] rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= SEED_ADDR;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_seed();
    logic [63:0] rd;
    apb_xfer(1'b0, '0, rd);
    if (rd !== seed_copy)
      note_mismatch("seed readback", seed_copy, rd);
  endtask

  task automatic program_seed(input logic [63:0] s);
    logic [63:0] rd;
    apb_xfer(1'b1, s, rd);
    seed_copy = s;
    seeds_used++;
    check_seed();
  endtask

  // Random phase: mostly well-formed messages, plus strays, abandoned
  // messages, length mismatches and fully random words.
  task automatic run_phase(input logic [63:0] s);
    int unsigned counted;
    int unsigned w;
    int unsigned pick;
    int unsigned n;
    logic [15:0] len;
    settle();
    program_seed(s);
    counted = 0;
    while (counted < PHASE_WORDS) begin
      pick = $urandom_range(0, 19);
      if (pick < 15) begin
        // Well-formed; mostly short, some longer.
        len = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(41, 120))
                                          : 16'($urandom_range(0, 40));
        queue_message(len, len, w);
        counted += w;
      end else if (pick < 17) begin
        // Length field unrelated to the bytes actually sent.
        queue_message(16'($urandom_range(0, 65535)), $urandom_range(0, 30), w);
        counted += w;
      end else if (pick == 17) begin
        // Words without msg_start, not counted: dropped when no message is open.
        n = $urandom_range(1, 3);
        for (int unsigned i = 0; i < n; i++)
          queue_word(rand64(), 4'($urandom_range(0, 15)), 1'b0, 1'($urandom_range(0, 1)),
                     16'($urandom_range(0, 65535)));
      end else if (pick == 18) begin
        // Abandoned message: open it, feed a few words, never close it.
        n = $urandom_range(0, 2);
        queue_word(rand64(), 4'($urandom_range(0, 15)), 1'b1, 1'b0,
                   16'($urandom_range(0, 65535)));
        for (int unsigned i = 0; i < n; i++)
          queue_word(rand64(), 4'($urandom_range(0, 15)), 1'b0, 1'b0,
                     16'($urandom_range(0, 65535)));
        counted += n + 1;
      end else begin
        queue_word(rand64(), 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)));
        counted++;
      end
    end
    // Close with a clean message so the engine ends the phase idle.
    queue_message(16'd13, 13, w);
  endtask

  // ---------------------------------------------------------------------
  // Output back-pressure: once traffic is flowing, refuse hashes for a long
  // stretch while the driver keeps offering, so the engine backs up.
  // ---------------------------------------------------------------------
  initial begin
    wait (items_taken >= 60);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    long_hold <= 1'b0;
  end

  initial begin
    #2_000_000;
    $display("timeout: %0d words taken, %0d hashes owed", items_taken,
             expected_hashes.size());
    $display("end of test: mismatches");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    clk       = 1'b0;
    rst       = 1'b1;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    long_hold = 1'b0;
    hash_if.ready           = 1'b0;
    words_if.valid          = 1'b0;
    words_if.data_word      = '0;
    words_if.byte_count     = '0;
    words_if.msg_start      = 1'b0;
    words_if.is_last        = 1'b0;
    words_if.message_length = '0;
    seed_copy      = mur64_pkg::SEED_RESET;
    acc_state      = '0;
    msg_open       = 1'b0;
    offering       = 1'b0;
    err_count      = 0;
    items_taken    = 0;
    hashes_checked = 0;
    strays_dropped = 0;
    seeds_used     = 0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Seed must come out of reset at its default.
    check_seed();

    // Directed words, default seed.
    // Empty message.
    queue_word('0, 4'd0, 1'b1, 1'b1, 16'd0);
    // Three-byte single-word message, junk above the valid bytes.
    queue_word(64'hdead_beef_0063_6261, 4'd3, 1'b1, 1'b1, 16'd3);
    // All-ones word with the largest length field.
    queue_word('1, 4'd8, 1'b1, 1'b1, 16'hffff);
    // All-zero full word.
    queue_word('0, 4'd8, 1'b1, 1'b1, 16'd8);
    // Oversized byte count on a single word.
    queue_word(64'h0123_4567_89ab_cdef, 4'd15, 1'b1, 1'b1, 16'd8);
    // Strays while idle, one marked last: no hash.
    queue_word('1, 4'd8, 1'b0, 1'b1, 16'hffff);
    queue_word(64'h5555_aaaa_5555_aaaa, 4'd0, 1'b0, 1'b0, 16'h0);
    // Three-word message ending in a four-byte tail.
    queue_word(64'hfedc_ba98_7654_3210, 4'd8, 1'b1, 1'b0, 16'd20);
    queue_word(64'h8000_0000_0000_0001, 4'd8, 1'b0, 1'b0, 16'h1234);
    queue_word('1, 4'd4, 1'b0, 1'b1, 16'h0);
    // New first while a message is open: restart.
    queue_word(64'h1111_2222_3333_4444, 4'd8, 1'b1, 1'b0, 16'd16);
    queue_word(64'h9999_8888_7777_6666, 4'd8, 1'b1, 1'b0, 16'd16);
    queue_word(64'h0f0f_0f0f_0f0f_0f0f, 4'd8, 1'b0, 1'b1, 16'd0);
    // Partial word not marked last, then the message carries on.
    queue_word(64'haaaa_bbbb_cccc_dddd, 4'd5, 1'b1, 1'b0, 16'd13);
    queue_word(64'h0000_ffff_0000_ffff, 4'd8, 1'b0, 1'b0, 16'd0);
    queue_word('1, 4'd0, 1'b0, 1'b1, 16'd0);
    // Length field disagreeing with the bytes sent.
    queue_word(64'h7fff_ffff_ffff_fffe, 4'd8, 1'b1, 1'b0, 16'd3);
    queue_word('1, 4'd7, 1'b0, 1'b1, 16'd0);
    // Oversized count in the middle, one-byte tail.
    queue_word(64'h0102_0304_0506_0708, 4'd9, 1'b1, 1'b0, 16'd9);
    queue_word(64'hffff_ffff_ffff_ff42, 4'd1, 1'b0, 1'b1, 16'd0);
    // Zero-byte first word that stays open, then a six-byte tail.
    queue_word('1, 4'd0, 1'b1, 1'b0, 16'd6);
    queue_word(64'hc3c3_3c3c_a5a5_5a5a, 4'd6, 1'b0, 1'b1, 16'd0);

    // Random phases across seed settings, the extremes first.
    run_phase('0);
    run_phase('1);
    run_phase({$urandom, $urandom});
    run_phase(64'h8000_0000_0000_0001);
    run_phase({$urandom, $urandom});

    settle();
    if (expected_hashes.size() != 0) begin
      $display("%0d hashes never arrived", expected_hashes.size());
      err_count += expected_hashes.size();
    end

    $display("covered %0d words (%0d dropped as strays), %0d hashes over %0d seed settings,",
             items_taken, strays_dropped, hashes_checked, seeds_used + 1);
    $display("with random bursts, output stalls and one long output hold-off");
    if (err_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches", err_count);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/mur64_pkg.sv
rtl/mur64_if.sv
rtl/mur64_datapath.sv
rtl/mur64_ctrl.sv
rtl/murmur64a_hash.sv
tb/sv/murmur64a_hash_tb.sv
